// File: sv/bsg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsg_pkg
// Shared types and constants for the bond segment geometry block.
// ----------------------------------------------------------------------------
package bsg_pkg;

  localparam int unsigned ATOM_SLOTS_DEF = 256;
  localparam int unsigned COORD_BITS_DEF = 24;

  localparam int unsigned IDX_W       = 8;   // slot index fields
  localparam int unsigned ADDR_EXT_W  = 16;  // index widened before cutting to the address
  localparam int unsigned OUT_COORD_W = 24;  // coordinate result fields
  localparam int unsigned LEN_W       = 25;  // length result field
  localparam int unsigned DIR_W       = 16;  // direction result fields, Q1.14
  localparam int unsigned DIR_FRAC    = 14;
  localparam int unsigned QUO_W       = DIR_FRAC + 1;
  localparam int unsigned DIV_STEPS   = DIR_FRAC;  // shift steps after the first compare
  localparam int unsigned CNT_W       = 6;

  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_BOND  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_CAP_B,
    ST_DIFF,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SUM,
    ST_SQRT,
    ST_DIVX_INIT,
    ST_DIVX,
    ST_DIVY_INIT,
    ST_DIVY,
    ST_DONE
  } bsg_state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_STORE,
    CMD_CAPTURE_IDX,
    CMD_READ_A,
    CMD_READ_B,
    CMD_CAPTURE_B,
    CMD_DIFF,
    CMD_SQ_X,
    CMD_SQ_Y,
    CMD_SUM,
    CMD_SQRT_STEP,
    CMD_DIVX_INIT,
    CMD_DIV_STEP,
    CMD_DIVY_INIT,
    CMD_LOAD_OUT
  } bsg_cmd_e;

  typedef struct packed {
    logic zero_len;
  } bsg_status_t;

endpackage
`default_nettype wire

// File: sv/bsg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsg_ctrl
// Sequencer: accepts transactions, steps the datapath through read, square,
// root and divide phases, and owns the result valid flag.
// ----------------------------------------------------------------------------
module bsg_ctrl
  import bsg_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        func_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  wire bsg_status_t status_i,
  output bsg_cmd_e         cmd_o
);

  localparam int unsigned SQRT_STEPS = COORD_BITS + 1;

  bsg_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_load;
  logic             cnt_last;

  assign cnt_last = (cnt_q == '0);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (func_i == FUNC_BOND)) begin
          state_d = ST_RD_A;
        end
      end
      ST_RD_A:  state_d = ST_RD_B;
      ST_RD_B:  state_d = ST_CAP_B;
      ST_CAP_B: state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_SQ_X;
      ST_SQ_X:  state_d = ST_SQ_Y;
      ST_SQ_Y:  state_d = ST_SUM;
      ST_SUM: begin
        state_d = ST_SQRT;
        cnt_d   = CNT_W'(SQRT_STEPS - 1);
      end
      ST_SQRT: begin
        if (cnt_last) begin
          state_d = ST_DIVX_INIT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_DIVX_INIT: begin
        if (status_i.zero_len) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_DIVX;
          cnt_d   = CNT_W'(DIV_STEPS - 1);
        end
      end
      ST_DIVX: begin
        if (cnt_last) begin
          state_d = ST_DIVY_INIT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_DIVY_INIT: begin
        state_d = ST_DIVY;
        cnt_d   = CNT_W'(DIV_STEPS - 1);
      end
      ST_DIVY: begin
        if (cnt_last) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = CMD_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o = (func_i == FUNC_BOND) ? CMD_CAPTURE_IDX : CMD_STORE;
        end
      end
      ST_RD_A:      cmd_o = CMD_READ_A;
      ST_RD_B:      cmd_o = CMD_READ_B;
      ST_CAP_B:     cmd_o = CMD_CAPTURE_B;
      ST_DIFF:      cmd_o = CMD_DIFF;
      ST_SQ_X:      cmd_o = CMD_SQ_X;
      ST_SQ_Y:      cmd_o = CMD_SQ_Y;
      ST_SUM:       cmd_o = CMD_SUM;
      ST_SQRT:      cmd_o = CMD_SQRT_STEP;
      ST_DIVX_INIT: cmd_o = status_i.zero_len ? CMD_NONE : CMD_DIVX_INIT;
      ST_DIVX:      cmd_o = CMD_DIV_STEP;
      ST_DIVY_INIT: cmd_o = CMD_DIVY_INIT;
      ST_DIVY:      cmd_o = CMD_DIV_STEP;
      ST_DONE:      cmd_o = out_load ? CMD_LOAD_OUT : CMD_NONE;
      default:      cmd_o = CMD_NONE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// File: sv/bsg_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsg_datapath
// Atom store, difference and square unit, bit-per-cycle square root,
// shared restoring divider and the result register.
// ----------------------------------------------------------------------------
module bsg_datapath
  import bsg_pkg::*;
#(
  parameter int unsigned ATOM_SLOTS = ATOM_SLOTS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire bsg_cmd_e                     cmd_i,
  output bsg_status_t                       status_o,
  input  wire logic        [IDX_W-1:0]      atom_index_i,
  input  wire logic signed [COORD_BITS-1:0] x_coord_i,
  input  wire logic signed [COORD_BITS-1:0] y_coord_i,
  input  wire logic signed [COORD_BITS-1:0] z_coord_i,
  input  wire logic        [IDX_W-1:0]      first_atom_i,
  input  wire logic        [IDX_W-1:0]      second_atom_i,
  output logic signed [OUT_COORD_W-1:0]     start_x_o,
  output logic signed [OUT_COORD_W-1:0]     start_y_o,
  output logic signed [OUT_COORD_W-1:0]     end_x_o,
  output logic signed [OUT_COORD_W-1:0]     end_y_o,
  output logic signed [OUT_COORD_W-1:0]     mid_depth_o,
  output logic        [LEN_W-1:0]           seg_length_o,
  output logic signed [DIR_W-1:0]           dir_x_o,
  output logic signed [DIR_W-1:0]           dir_y_o,
  output logic                              zero_length_o
);

  localparam int unsigned CB      = COORD_BITS;
  localparam int unsigned ENTRY_W = 3 * CB;
  localparam int unsigned AW      = (ATOM_SLOTS > 1) ? $clog2(ATOM_SLOTS) : 1;
  localparam int unsigned ROOT_W  = CB + 1;
  localparam int unsigned RAD_W   = 2 * ROOT_W;
  localparam int unsigned SREM_W  = CB + 4;
  localparam int unsigned DREM_W  = CB + 2;

  // ---------------- atom store ----------------
  logic [ENTRY_W-1:0]    mem_q [ATOM_SLOTS];
  logic [ENTRY_W-1:0]    rd_data_q;
  logic                  rd_ok_q;
  logic [ADDR_EXT_W-1:0] wr_ext, rd_ext;
  logic [IDX_W-1:0]      first_q, second_q, rd_idx;
  logic                  wr_in_range, rd_in_range;

  assign wr_ext      = ADDR_EXT_W'(atom_index_i);
  assign rd_idx      = (cmd_i == CMD_READ_B) ? second_q : first_q;
  assign rd_ext      = ADDR_EXT_W'(rd_idx);
  assign wr_in_range = (32'(atom_index_i) < 32'(ATOM_SLOTS));
  assign rd_in_range = (32'(rd_idx) < 32'(ATOM_SLOTS));

  always_ff @(posedge clk_i) begin
    if ((cmd_i == CMD_STORE) && wr_in_range) begin
      mem_q[wr_ext[AW-1:0]] <= {x_coord_i, y_coord_i, z_coord_i};
    end
    if ((cmd_i == CMD_READ_A) || (cmd_i == CMD_READ_B)) begin
      if (rd_in_range) begin
        rd_data_q <= mem_q[rd_ext[AW-1:0]];
      end
      rd_ok_q <= rd_in_range;
    end
    if (cmd_i == CMD_CAPTURE_IDX) begin
      first_q  <= first_atom_i;
      second_q <= second_atom_i;
    end
  end

  // slots beyond the store read as zero
  logic [ENTRY_W-1:0] entry;
  assign entry = rd_ok_q ? rd_data_q : '0;

  // ---------------- endpoints, difference, squares ----------------
  logic signed [CB-1:0]   ax_q, ay_q, az_q, bx_q, by_q, bz_q, mid_q;
  logic signed [CB:0]     dx_w, dy_w, zs_w;
  logic        [CB:0]     magx_w, magy_w;
  logic        [CB-1:0]   magx_q, magy_q, mul_a;
  logic                   sgnx_q, sgny_q;
  logic        [2*CB-1:0] prod, sqx_q, sqy_q;

  assign dx_w   = $signed({bx_q[CB-1], bx_q}) - $signed({ax_q[CB-1], ax_q});
  assign dy_w   = $signed({by_q[CB-1], by_q}) - $signed({ay_q[CB-1], ay_q});
  assign zs_w   = $signed({az_q[CB-1], az_q}) + $signed({bz_q[CB-1], bz_q});
  assign magx_w = dx_w[CB] ? -dx_w : dx_w;
  assign magy_w = dy_w[CB] ? -dy_w : dy_w;
  assign mul_a  = (cmd_i == CMD_SQ_Y) ? magy_q : magx_q;
  assign prod   = mul_a * mul_a;

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_READ_B) begin
      ax_q <= entry[ENTRY_W-1 -: CB];
      ay_q <= entry[2*CB-1 -: CB];
      az_q <= entry[CB-1:0];
    end
    if (cmd_i == CMD_CAPTURE_B) begin
      bx_q <= entry[ENTRY_W-1 -: CB];
      by_q <= entry[2*CB-1 -: CB];
      bz_q <= entry[CB-1:0];
    end
    if (cmd_i == CMD_DIFF) begin
      magx_q <= magx_w[CB-1:0];
      magy_q <= magy_w[CB-1:0];
      sgnx_q <= dx_w[CB];
      sgny_q <= dy_w[CB];
      mid_q  <= zs_w[CB:1];  // arithmetic halve, rounds toward minus infinity
    end
    if (cmd_i == CMD_SQ_X) begin
      sqx_q <= prod;
    end
    if (cmd_i == CMD_SQ_Y) begin
      sqy_q <= prod;
    end
  end

  // ---------------- square root, one root bit per cycle ----------------
  logic [RAD_W-1:0]  rad_q;
  logic [SREM_W-1:0] srem_q, srem_sh, strial;
  logic [ROOT_W-1:0] root_q;
  logic              sge;

  assign srem_sh = {srem_q[SREM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign strial  = SREM_W'({root_q, 2'b01});
  assign sge     = (srem_sh >= strial);

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_SUM) begin
      rad_q  <= RAD_W'(sqx_q) + RAD_W'(sqy_q);
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i == CMD_SQRT_STEP) begin
      rad_q  <= rad_q << 2;
      srem_q <= sge ? (srem_sh - strial) : srem_sh;
      root_q <= {root_q[ROOT_W-2:0], sge};
    end
  end

  assign status_o.zero_len = (root_q == '0);

  // ---------------- restoring divider: mag * 2^14 / length ----------------
  // The magnitude never exceeds the length, so the top quotient bit is a
  // single compare; the rest are shift-and-subtract steps.
  logic [DREM_W-1:0] drem_q, dnum, dsh, dlen;
  logic [QUO_W-1:0]  quo_q;
  logic              dge_init, dge_step;
  logic signed [DIR_W-1:0] quo_ext, dirx_q, diry_w;

  assign dlen     = DREM_W'(root_q);
  assign dnum     = (cmd_i == CMD_DIVY_INIT) ? DREM_W'(magy_q) : DREM_W'(magx_q);
  assign dge_init = (dnum >= dlen);
  assign dsh      = {drem_q[DREM_W-2:0], 1'b0};
  assign dge_step = (dsh >= dlen);
  assign quo_ext  = DIR_W'(quo_q);
  assign diry_w   = sgny_q ? -quo_ext : quo_ext;

  always_ff @(posedge clk_i) begin
    if ((cmd_i == CMD_DIVX_INIT) || (cmd_i == CMD_DIVY_INIT)) begin
      drem_q <= dge_init ? (dnum - dlen) : dnum;
      quo_q  <= QUO_W'(dge_init);
    end else if (cmd_i == CMD_DIV_STEP) begin
      drem_q <= dge_step ? (dsh - dlen) : dsh;
      quo_q  <= {quo_q[QUO_W-2:0], dge_step};
    end
    if (cmd_i == CMD_DIVY_INIT) begin
      dirx_q <= sgnx_q ? -quo_ext : quo_ext;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD_OUT) begin
      start_x_o     <= OUT_COORD_W'(ax_q);
      start_y_o     <= OUT_COORD_W'(ay_q);
      end_x_o       <= OUT_COORD_W'(bx_q);
      end_y_o       <= OUT_COORD_W'(by_q);
      mid_depth_o   <= OUT_COORD_W'(mid_q);
      seg_length_o  <= LEN_W'(root_q);
      zero_length_o <= status_o.zero_len;
      dir_x_o       <= status_o.zero_len ? '0 : dirx_q;
      dir_y_o       <= status_o.zero_len ? '0 : diry_w;
    end
  end

endmodule
`default_nettype wire

// File: sv/bond_segment_geometry.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bond_segment_geometry
// Atom coordinate store with planar bond length and unit direction.
// ----------------------------------------------------------------------------
// A store transaction (func 0) writes x, y, z into one slot and produces no
// result; slots at or beyond ATOM_SLOTS are ignored on write and read as
// zero. A bond transaction (func 1) steps through the square root, which
// resolves one root bit per cycle, and the single shared divider, which
// produces one quotient bit per cycle for each of the two direction
// components; the divider is skipped when the endpoints coincide in the
// plane. Store slots are undefined until written; a bond must name only
// written slots. One result register decouples the output, so the next
// transaction is taken while a result waits to be read.
// ----------------------------------------------------------------------------
module bond_segment_geometry
  import bsg_pkg::*;
#(
  parameter int unsigned ATOM_SLOTS = ATOM_SLOTS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         func_i,
  input  wire logic        [IDX_W-1:0]      atom_index_i,
  input  wire logic signed [COORD_BITS-1:0] x_coord_i,
  input  wire logic signed [COORD_BITS-1:0] y_coord_i,
  input  wire logic signed [COORD_BITS-1:0] z_coord_i,
  input  wire logic        [IDX_W-1:0]      first_atom_i,
  input  wire logic        [IDX_W-1:0]      second_atom_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [OUT_COORD_W-1:0]     start_x_o,
  output logic signed [OUT_COORD_W-1:0]     start_y_o,
  output logic signed [OUT_COORD_W-1:0]     end_x_o,
  output logic signed [OUT_COORD_W-1:0]     end_y_o,
  output logic signed [OUT_COORD_W-1:0]     mid_depth_o,
  output logic        [LEN_W-1:0]           seg_length_o,
  output logic signed [DIR_W-1:0]           dir_x_o,
  output logic signed [DIR_W-1:0]           dir_y_o,
  output logic                              zero_length_o
);

  bsg_cmd_e    cmd;
  bsg_status_t status;

  bsg_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bsg_datapath #(
    .ATOM_SLOTS (ATOM_SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .atom_index_i  (atom_index_i),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .z_coord_i     (z_coord_i),
    .first_atom_i  (first_atom_i),
    .second_atom_i (second_atom_i),
    .start_x_o     (start_x_o),
    .start_y_o     (start_y_o),
    .end_x_o       (end_x_o),
    .end_y_o       (end_y_o),
    .mid_depth_o   (mid_depth_o),
    .seg_length_o  (seg_length_o),
    .dir_x_o       (dir_x_o),
    .dir_y_o       (dir_y_o),
    .zero_length_o (zero_length_o)
  );

endmodule
`default_nettype wire

// File: tb/sv/bond_segment_geometry_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bond_segment_geometry_tb
// Self-checking bench: writes atoms into the coordinate store, issues bond
// transactions between written slots and checks every result field against
// an in-bench predictor. Covers coordinate extremes, coincident endpoints,
// axis-aligned bonds, random traffic with idle bursts on both sides and a long
// output stall that backs up the input.
// ----------------------------------------------------------------------------
module bond_segment_geometry_tb;
  import bsg_pkg::*;

  localparam int COORD_W      = COORD_BITS_DEF;
  localparam int N_SLOTS      = ATOM_SLOTS_DEF;
  localparam int COORD_MIN    = -(1 << (COORD_W - 1));
  localparam int COORD_MAX    = (1 << (COORD_W - 1)) - 1;
  localparam longint DIR_ONE  = 1 << DIR_FRAC;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int N_PRESSURE   = 24;
  localparam int N_RANDOM     = 370;
  localparam int N_TAIL       = 30;

  typedef struct {
    logic signed [OUT_COORD_W-1:0] start_x;
    logic signed [OUT_COORD_W-1:0] start_y;
    logic signed [OUT_COORD_W-1:0] end_x;
    logic signed [OUT_COORD_W-1:0] end_y;
    logic signed [OUT_COORD_W-1:0] mid_depth;
    logic        [LEN_W-1:0]       seg_length;
    logic signed [DIR_W-1:0]       dir_x;
    logic signed [DIR_W-1:0]       dir_y;
    logic                          zero_length;
  } bond_geom_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                      in_valid_i;
  logic                      in_ready_o;
  logic                      func_i;
  logic [IDX_W-1:0]          atom_index_i;
  logic signed [COORD_W-1:0] x_coord_i;
  logic signed [COORD_W-1:0] y_coord_i;
  logic signed [COORD_W-1:0] z_coord_i;
  logic [IDX_W-1:0]          first_atom_i;
  logic [IDX_W-1:0]          second_atom_i;

  logic                          out_valid_o;
  logic                          out_ready_i;
  logic signed [OUT_COORD_W-1:0] start_x_o;
  logic signed [OUT_COORD_W-1:0] start_y_o;
  logic signed [OUT_COORD_W-1:0] end_x_o;
  logic signed [OUT_COORD_W-1:0] end_y_o;
  logic signed [OUT_COORD_W-1:0] mid_depth_o;
  logic        [LEN_W-1:0]       seg_length_o;
  logic signed [DIR_W-1:0]       dir_x_o;
  logic signed [DIR_W-1:0]       dir_y_o;
  logic                          zero_length_o;

  // shadow of the coordinate store
  logic signed [COORD_W-1:0] store_x [N_SLOTS];
  logic signed [COORD_W-1:0] store_y [N_SLOTS];
  logic signed [COORD_W-1:0] store_z [N_SLOTS];
  bit                        slot_written [N_SLOTS];
  int                        written_slots [$];

  bond_geom_t geom_expect_q [$];
  int         err_count      = 0;
  bit         src_idle_on    = 1'b1;
  bit         sink_idle_on   = 1'b1;
  int         sink_hold_left = 0;

  bond_segment_geometry u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .atom_index_i (atom_index_i),
    .x_coord_i    (x_coord_i),
    .y_coord_i    (y_coord_i),
    .z_coord_i    (z_coord_i),
    .first_atom_i (first_atom_i),
    .second_atom_i(second_atom_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .start_x_o    (start_x_o),
    .start_y_o    (start_y_o),
    .end_x_o      (end_x_o),
    .end_y_o      (end_y_o),
    .mid_depth_o  (mid_depth_o),
    .seg_length_o (seg_length_o),
    .dir_x_o      (dir_x_o),
    .dir_y_o      (dir_y_o),
    .zero_length_o(zero_length_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // floor(sqrt(v)), two bits per step; v stays below 2^50
  function automatic longint isqrt_floor(longint v);
    longint rem, root, trial;
    rem  = 0;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      rem   = (rem << 2) | ((v >> (2 * i)) & 3);
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Q1.14 component, truncated toward zero
  function automatic logic signed [DIR_W-1:0] dir_component(longint d, longint len);
    longint q;
    q = (((d < 0) ? -d : d) * DIR_ONE) / len;
    if (d < 0) q = -q;
    return q[DIR_W-1:0];
  endfunction

  function automatic bond_geom_t predict_bond_geometry(int first, int second);
    bond_geom_t r;
    longint dx, dy, len, mid;
    dx  = longint'(store_x[second]) - longint'(store_x[first]);
    dy  = longint'(store_y[second]) - longint'(store_y[first]);
    len = isqrt_floor(dx * dx + dy * dy);
    mid = (longint'(store_z[first]) + longint'(store_z[second])) >>> 1;
    r.start_x     = store_x[first];
    r.start_y     = store_y[first];
    r.end_x       = store_x[second];
    r.end_y       = store_y[second];
    r.mid_depth   = mid[OUT_COORD_W-1:0];
    r.seg_length  = len[LEN_W-1:0];
    r.zero_length = (len == 0);
    if (len == 0) begin
      r.dir_x = '0;
      r.dir_y = '0;
    end else begin
      r.dir_x = dir_component(dx, len);
      r.dir_y = dir_component(dy, len);
    end
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord();
    longint v;
    v = longint'($urandom);
    case ($urandom_range(0, 7))
      0: v = COORD_MIN;
      1: v = COORD_MAX;
      2: v = longint'($urandom_range(0, 8191)) - 4096;
      3: v = COORD_MIN + longint'($urandom_range(0, 255));
      4: v = COORD_MAX - longint'($urandom_range(0, 255));
      default: ;
    endcase
    return v[COORD_W-1:0];
  endfunction

  function automatic int pick_written();
    return written_slots[$urandom_range(0, written_slots.size() - 1)];
  endfunction

  function automatic void compare_field(string name, logic signed [31:0] exp_v,
                                        logic signed [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      err_count++;
    end
  endfunction

  task automatic check_result();
    bond_geom_t e;
    if (geom_expect_q.size() == 0) begin
      $display("%0t: result with no bond transaction pending", $time);
      err_count++;
    end else begin
      e = geom_expect_q.pop_front();
      compare_field("start_x", e.start_x, start_x_o);
      compare_field("start_y", e.start_y, start_y_o);
      compare_field("end_x", e.end_x, end_x_o);
      compare_field("end_y", e.end_y, end_y_o);
      compare_field("mid_depth", e.mid_depth, mid_depth_o);
      compare_field("seg_length", e.seg_length, seg_length_o);
      compare_field("dir_x", e.dir_x, dir_x_o);
      compare_field("dir_y", e.dir_y, dir_y_o);
      compare_field("zero_length", e.zero_length, zero_length_o);
    end
  endtask

  // Entered and left at a rising edge; valid stays high between back-to-back
  // transactions and is only dropped for an idle burst or a drain.
  task automatic send_txn(input logic fn, input logic [IDX_W-1:0] slot,
                          input logic signed [COORD_W-1:0] x, y, z,
                          input logic [IDX_W-1:0] first, second);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= fn;
    atom_index_i  <= slot;
    x_coord_i     <= x;
    y_coord_i     <= y;
    z_coord_i     <= z;
    first_atom_i  <= first;
    second_atom_i <= second;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (fn == FUNC_STORE) begin
      store_x[slot] = x;
      store_y[slot] = y;
      store_z[slot] = z;
      if (!slot_written[slot]) begin
        slot_written[slot] = 1'b1;
        written_slots.push_back(slot);
      end
    end else begin
      geom_expect_q.push_back(predict_bond_geometry(first, second));
    end
  endtask

  // unused fields carry random noise
  task automatic store_atom(input int slot, input logic signed [COORD_W-1:0] x, y, z);
    send_txn(FUNC_STORE, IDX_W'(slot), x, y, z, IDX_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic send_bond(input int first, input int second);
    send_txn(FUNC_BOND, IDX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
             COORD_W'($urandom), IDX_W'(first), IDX_W'(second));
  endtask

  task automatic send_random_bond();
    int first_slot, second_slot;
    first_slot  = pick_written();
    second_slot = ($urandom_range(0, 9) == 0) ? first_slot : pick_written();
    send_bond(first_slot, second_slot);
  endtask

  // stores sometimes reuse another slot's x and/or y to hit coincident
  // and axis-aligned bonds
  task automatic send_random_item();
    int src;
    logic signed [COORD_W-1:0] x, y;
    if (written_slots.size() < 2 || $urandom_range(0, 9) < 4) begin
      x = pick_coord();
      y = pick_coord();
      if (written_slots.size() > 0) begin
        src = pick_written();
        case ($urandom_range(0, 9))
          0: begin
            x = store_x[src];
            y = store_y[src];
          end
          1: x = store_x[src];
          2: y = store_y[src];
          default: ;
        endcase
      end
      store_atom($urandom_range(0, N_SLOTS - 1), x, y, pick_coord());
    end else begin
      send_random_bond();
    end
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (geom_expect_q.size() != 0);
  endtask

  task automatic test_store_extremes();
    store_atom(0, COORD_W'(COORD_MIN), COORD_W'(COORD_MIN), COORD_W'(COORD_MIN));
    store_atom(N_SLOTS - 1, COORD_W'(COORD_MAX), COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
    store_atom(170, 0, 0, -3);
    store_atom(85, 4096, 0, 0);
  endtask

  task automatic test_bond_extremes();
    send_bond(0, N_SLOTS - 1);
    send_bond(N_SLOTS - 1, 0);
    send_bond(170, 0);
  endtask

  task automatic test_zero_length();
    send_bond(0, 0);
    send_bond(N_SLOTS - 1, N_SLOTS - 1);
    store_atom(9, COORD_W'(COORD_MIN), COORD_W'(COORD_MIN), COORD_W'(COORD_MAX));
    send_bond(0, 9);
    send_bond(9, 0);
  endtask

  task automatic test_axis_and_rounding();
    send_bond(170, 85);
    send_bond(85, 170);
    store_atom(3, 0, -5000, 7);
    store_atom(4, 0, 5000, -8);
    send_bond(3, 4);
    send_bond(4, 3);
    store_atom(10, 1, 1, 1);
    store_atom(12, 3, 4, 5);
    send_bond(10, 12);
    send_bond(12, 10);
  endtask

  // long output stall while the sender keeps pushing bonds
  task automatic test_backpressure();
    wait_results_drained();
    @(negedge clk_i) sink_hold_left = HOLD_CYCLES;
    @(posedge clk_i);
    src_idle_on = 1'b0;
    repeat (N_PRESSURE) send_random_bond();
    src_idle_on = 1'b1;
    wait_results_drained();
  endtask

  task automatic test_random_mix();
    repeat (N_RANDOM) send_random_item();
  endtask

  task automatic test_quiet_tail();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    repeat (N_TAIL) send_random_item();
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) check_result();
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left  = $urandom_range(1, 14) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    func_i        = FUNC_STORE;
    atom_index_i  = '0;
    x_coord_i     = '0;
    y_coord_i     = '0;
    z_coord_i     = '0;
    first_atom_i  = '0;
    second_atom_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_store_extremes();
    test_bond_extremes();
    test_zero_length();
    test_axis_and_rounding();
    test_backpressure();
    test_random_mix();
    test_quiet_tail();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
